@@ rtl/ffha_pkg.sv @@
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared constants, codes and sequencer states of the first-fit allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

	localparam int MAX_SEGMENTS_DEF = 64;
	localparam int ADDRESS_BITS_DEF = 16;
	localparam int OWNER_W          = 8;
	localparam int AMOUNT_W         = 16;
	localparam int ADDR_OUT_W       = 16;
	localparam int HEAP_W           = 16;
	localparam logic [HEAP_W-1:0] HEAP_RESET = 16'hFFFF;

	typedef enum logic [0:0] {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_NOFIT   = 2'd1,
		STAT_FULL    = 2'd2,
		STAT_NOMATCH = 2'd3
	} status_t;

	typedef enum logic [4:0] {
		S_INIT,
		S_IDLE,
		S_A_RD,
		S_A_EV,
		S_SH_RD,
		S_SH_WR,
		S_WR_TAIL,
		S_WR_HEAD,
		S_F_RD,
		S_F_EV,
		S_N_RD,
		S_N_EV,
		S_RM_RD,
		S_RM_WR,
		S_WB_CUR,
		S_P_RD,
		S_P_EV,
		S_FIN
	} state_t;

endpackage

@@ rtl/ffha_if.sv @@
// ----------------------------------------------------------------------------
// ffha_req_if / ffha_rsp_if
// Valid/ready channels for requests and responses of the allocator.
// ----------------------------------------------------------------------------
interface ffha_req_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [7:0]  owner_id;
	logic [15:0] amount;
	logic [15:0] start_address;

	modport source (output valid, opcode, owner_id, amount, start_address, input ready);
	modport sink   (input valid, opcode, owner_id, amount, start_address, output ready);
endinterface

interface ffha_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [15:0] address;

	modport source (output valid, status, address, input ready);
	modport sink   (input valid, status, address, output ready);
endinterface

@@ rtl/ffha_seg_mem.sv @@
// ----------------------------------------------------------------------------
// ffha_seg_mem
// Segment table storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ffha_seg_mem #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 41
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ rtl/first_fit_heap_allocator.sv @@
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit heap segment allocator with split on allocate and merge on free.
// ----------------------------------------------------------------------------
// Sequencing: allocate reads then evaluates each segment scanned, and on a
//   split moves each tail entry down with a table read and a write; free scans
//   likewise, and on each merge moves later entries up with a read and a write.
// Throughput: one transaction at a time; req.ready is high only when idle.
// Reset: the S_INIT state rebuilds entry zero as one free segment of heap_size;
//   a heap_size write does the same.
module first_fit_heap_allocator
	import ffha_pkg::*;
#(
	parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
	parameter int ADDRESS_BITS = ADDRESS_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	ffha_req_if.sink          req,
	ffha_rsp_if.source        rsp,
	input  logic              cfg_we,
	input  logic [HEAP_W-1:0] cfg_data
);
	localparam int AB   = ADDRESS_BITS;
	localparam int IW   = $clog2(MAX_SEGMENTS);
	localparam int CNTW = $clog2(MAX_SEGMENTS + 1);
	localparam int EW   = 1 + OWNER_W + 2 * AB;
	// common width for comparing sizes against 16-bit request fields
	localparam int CW   = (AB > 16) ? AB : 16;

	state_t state_q, state_d;

	logic [CNTW-1:0]       i_q, i_d, k_q, k_d, cnt_q, cnt_d;
	logic [EW-1:0]         cur_q, cur_d;
	logic                  rm_final_q, rm_final_d;
	logic [HEAP_W-1:0]     heap_q, heap_d;
	logic [OWNER_W-1:0]    owner_q;
	logic [AMOUNT_W-1:0]   amount_q;
	logic [AMOUNT_W-1:0]   start_in_q;
	status_t               res_stat_q, res_stat_d;
	logic [ADDR_OUT_W-1:0] res_addr_q, res_addr_d;
	logic                  out_valid_q, out_valid_d;
	logic [1:0]            out_stat_q, out_stat_d;
	logic [ADDR_OUT_W-1:0] out_addr_q, out_addr_d;

	// table port
	logic          mem_we;
	logic [IW-1:0] mem_waddr, mem_raddr;
	logic [EW-1:0] mem_wdata, rdata;

	ffha_seg_mem #(.DEPTH(MAX_SEGMENTS), .WIDTH(EW)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (rdata)
	);

	// entry layout: {free, owner, start, size}
	logic               rd_free, cur_free;
	logic [OWNER_W-1:0] rd_owner;
	logic [AB-1:0]      rd_start, rd_size, cur_start, cur_size;
	assign rd_free   = rdata[EW-1];
	assign rd_owner  = rdata[EW-2 -: OWNER_W];
	assign rd_start  = rdata[2*AB-1 -: AB];
	assign rd_size   = rdata[AB-1:0];
	assign cur_free  = cur_q[EW-1];
	assign cur_start = cur_q[2*AB-1 -: AB];
	assign cur_size  = cur_q[AB-1:0];

	logic [CW-1:0] amt_cw, rd_size_cw, rd_start_cw, start_in_cw, cur_start_cw;
	logic [CW-1:0] mask_cw;
	assign mask_cw      = CW'({AB{1'b1}});
	assign amt_cw       = CW'(amount_q);
	assign rd_size_cw   = CW'(rd_size);
	assign rd_start_cw  = CW'(rd_start);
	assign start_in_cw  = CW'(start_in_q) & mask_cw;
	assign cur_start_cw = CW'(cur_start);

	logic [CNTW-1:0] i_inc, k_inc, k_dec, i_dec;
	assign i_inc = i_q + CNTW'(1);
	assign i_dec = i_q - CNTW'(1);
	assign k_inc = k_q + CNTW'(1);
	assign k_dec = k_q - CNTW'(1);

	assign req.ready   = (state_q == S_IDLE) && !cfg_we;
	assign rsp.valid   = out_valid_q;
	assign rsp.status  = out_stat_q;
	assign rsp.address = out_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			heap_q      <= HEAP_RESET;
			cnt_q       <= CNTW'(1);
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			heap_q      <= heap_d;
			cnt_q       <= cnt_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		i_q        <= i_d;
		k_q        <= k_d;
		cur_q      <= cur_d;
		rm_final_q <= rm_final_d;
		res_stat_q <= res_stat_d;
		res_addr_q <= res_addr_d;
		out_stat_q <= out_stat_d;
		out_addr_q <= out_addr_d;
		if (req.valid && req.ready) begin
			owner_q    <= req.owner_id;
			amount_q   <= req.amount;
			start_in_q <= req.start_address;
		end
	end

	always_comb begin
		state_d     = state_q;
		heap_d      = heap_q;
		cnt_d       = cnt_q;
		i_d         = i_q;
		k_d         = k_q;
		cur_d       = cur_q;
		rm_final_d  = rm_final_q;
		res_stat_d  = res_stat_q;
		res_addr_d  = res_addr_q;
		out_stat_d  = out_stat_q;
		out_addr_d  = out_addr_q;
		out_valid_d = out_valid_q && !rsp.ready;
		mem_we      = 1'b0;
		mem_waddr   = i_q[IW-1:0];
		mem_wdata   = cur_q;
		mem_raddr   = i_q[IW-1:0];

		unique case (state_q)
			S_INIT: begin
				mem_we    = 1'b1;
				mem_waddr = '0;
				mem_wdata = {1'b1, {OWNER_W{1'b0}}, {AB{1'b0}}, AB'(CW'(heap_q))};
				cnt_d     = CNTW'(1);
				state_d   = S_IDLE;
			end
			S_IDLE: begin
				if (req.valid && req.ready) begin
					i_d        = '0;
					res_addr_d = '0;
					if (opcode_t'(req.opcode) == OP_FREE) begin
						res_stat_d = STAT_NOMATCH;
						state_d    = S_F_RD;
					end else if (req.amount == '0) begin
						res_stat_d = STAT_NOFIT;
						state_d    = S_FIN;
					end else begin
						res_stat_d = STAT_NOFIT;
						state_d    = S_A_RD;
					end
				end
			end
			// allocate: scan for first free segment that fits
			S_A_RD: begin
				state_d = (i_q == cnt_q) ? S_FIN : S_A_EV;
			end
			S_A_EV: begin
				if (rd_free && rd_size_cw >= amt_cw) begin
					if (rd_size_cw == amt_cw) begin
						mem_we     = 1'b1;
						mem_wdata  = {1'b0, owner_q, rd_start, rd_size};
						res_stat_d = STAT_OK;
						res_addr_d = rd_start_cw[ADDR_OUT_W-1:0];
						state_d    = S_FIN;
					end else if (cnt_q == CNTW'(MAX_SEGMENTS)) begin
						res_stat_d = STAT_FULL;
						state_d    = S_FIN;
					end else begin
						cur_d   = rdata;
						k_d     = cnt_q;
						state_d = S_SH_RD;
					end
				end else begin
					i_d     = i_inc;
					state_d = S_A_RD;
				end
			end
			// open a hole at i+1 by shifting the tail down one slot
			S_SH_RD: begin
				mem_raddr = k_dec[IW-1:0];
				state_d   = (k_q > i_inc) ? S_SH_WR : S_WR_TAIL;
			end
			S_SH_WR: begin
				mem_we    = 1'b1;
				mem_waddr = k_q[IW-1:0];
				mem_wdata = rdata;
				k_d       = k_dec;
				state_d   = S_SH_RD;
			end
			S_WR_TAIL: begin
				mem_we    = 1'b1;
				mem_waddr = i_inc[IW-1:0];
				mem_wdata = {1'b1, {OWNER_W{1'b0}}, AB'(cur_start_cw + amt_cw),
				             AB'(CW'(cur_size) - amt_cw)};
				state_d   = S_WR_HEAD;
			end
			S_WR_HEAD: begin
				mem_we     = 1'b1;
				mem_wdata  = {1'b0, owner_q, cur_start, AB'(amt_cw)};
				cnt_d      = cnt_q + CNTW'(1);
				res_stat_d = STAT_OK;
				res_addr_d = cur_start_cw[ADDR_OUT_W-1:0];
				state_d    = S_FIN;
			end
			// free: find owned segment with matching owner and start
			S_F_RD: begin
				state_d = (i_q == cnt_q) ? S_FIN : S_F_EV;
			end
			S_F_EV: begin
				if (!rd_free && rd_owner == owner_q && rd_start_cw == start_in_cw) begin
					cur_d      = {1'b1, {OWNER_W{1'b0}}, rd_start, rd_size};
					res_stat_d = STAT_OK;
					state_d    = (i_inc < cnt_q) ? S_N_RD : S_WB_CUR;
				end else begin
					i_d     = i_inc;
					state_d = S_F_RD;
				end
			end
			S_N_RD: begin
				mem_raddr = i_inc[IW-1:0];
				state_d   = S_N_EV;
			end
			S_N_EV: begin
				if (rd_free) begin
					cur_d      = {cur_free, {OWNER_W{1'b0}}, cur_start, cur_size + rd_size};
					k_d        = i_inc;
					rm_final_d = 1'b0;
					state_d    = S_RM_RD;
				end else begin
					state_d = S_WB_CUR;
				end
			end
			// close the slot at k by shifting later entries up
			S_RM_RD: begin
				mem_raddr = k_inc[IW-1:0];
				if (k_inc < cnt_q) begin
					state_d = S_RM_WR;
				end else begin
					cnt_d   = cnt_q - CNTW'(1);
					state_d = rm_final_q ? S_FIN : S_WB_CUR;
				end
			end
			S_RM_WR: begin
				mem_we    = 1'b1;
				mem_waddr = k_q[IW-1:0];
				mem_wdata = rdata;
				k_d       = k_inc;
				state_d   = S_RM_RD;
			end
			S_WB_CUR: begin
				mem_we  = 1'b1;
				state_d = (i_q != '0) ? S_P_RD : S_FIN;
			end
			S_P_RD: begin
				mem_raddr = i_dec[IW-1:0];
				state_d   = S_P_EV;
			end
			S_P_EV: begin
				if (rd_free) begin
					mem_we     = 1'b1;
					mem_waddr  = i_dec[IW-1:0];
					mem_wdata  = {rd_free, rd_owner, rd_start, rd_size + cur_size};
					k_d        = i_q;
					rm_final_d = 1'b1;
					state_d    = S_RM_RD;
				end else begin
					state_d = S_FIN;
				end
			end
			// hand result to the output register once it is free
			S_FIN: begin
				if (!out_valid_d) begin
					out_valid_d = 1'b1;
					out_stat_d  = res_stat_q;
					out_addr_d  = (res_stat_q == STAT_OK) ? res_addr_q : '0;
					state_d     = S_IDLE;
				end
			end
			default: state_d = S_INIT;
		endcase

		// heap_size write rebuilds the table
		if (cfg_we) begin
			heap_d  = cfg_data;
			state_d = S_INIT;
		end
	end
endmodule
